[src/mwo_pkg.sv]
`timescale 1ns / 1ps

package mwo_pkg;

   // fixed number formats
   localparam int PhaseBits    = 32;
   localparam int FracBits     = 16;
   localparam int SampleBits   = FracBits + 2;
   localparam int CordicIters  = 30;
   localparam int CordicXyBits = 34;
   localparam int CordicZBits  = 32;
   localparam int CordicShift  = 30 - FracBits;

   localparam logic signed [CordicXyBits-1:0] CordicGain = 34'sd652032874;
   localparam logic signed [SampleBits-1:0]   OneF       = 18'sd65536;
   localparam logic signed [SampleBits-1:0]   MinusOneF  = -18'sd65536;

   // register indexes
   typedef enum logic [1:0] {
      REG_WAVE_MODE = 2'd0,
      REG_INIT_INC  = 2'd1,
      REG_INIT_PH   = 2'd2,
      REG_NONE      = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_SINE     = 2'd0,
      MODE_SAW      = 2'd1,
      MODE_SQUARE   = 2'd2,
      MODE_TRIANGLE = 2'd3
   } wave_mode_type;

   // cordic handshake between sequencer and rotator
   typedef struct packed {
      logic                 start;
      logic [PhaseBits-1:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [SampleBits-1:0] cos_val;
      logic signed [SampleBits-1:0] sin_val;
   } cordic_rsp_type;

   // arctangent of 2^-i, turn fraction scaled by 2^32
   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] r;
      unique case (idx)
         5'd0:  r = 30'h20000000;
         5'd1:  r = 30'h12E4051E;
         5'd2:  r = 30'h09FB385B;
         5'd3:  r = 30'h051111D4;
         5'd4:  r = 30'h028B0D43;
         5'd5:  r = 30'h0145D7E1;
         5'd6:  r = 30'h00A2F61E;
         5'd7:  r = 30'h00517C55;
         5'd8:  r = 30'h0028BE53;
         5'd9:  r = 30'h00145F2F;
         5'd10: r = 30'h000A2F98;
         5'd11: r = 30'h000517CC;
         5'd12: r = 30'h00028BE6;
         5'd13: r = 30'h000145F3;
         5'd14: r = 30'h0000A2FA;
         5'd15: r = 30'h0000517D;
         5'd16: r = 30'h000028BE;
         5'd17: r = 30'h0000145F;
         5'd18: r = 30'h00000A30;
         5'd19: r = 30'h00000518;
         5'd20: r = 30'h0000028C;
         5'd21: r = 30'h00000146;
         5'd22: r = 30'h000000A3;
         5'd23: r = 30'h00000051;
         5'd24: r = 30'h00000029;
         5'd25: r = 30'h00000014;
         5'd26: r = 30'h0000000A;
         5'd27: r = 30'h00000005;
         5'd28: r = 30'h00000003;
         5'd29: r = 30'h00000001;
         default: r = 30'h0;
      endcase
      return r;
   endfunction

endpackage

[src/mwo_cordic.sv]
`timescale 1ns / 1ps

module mwo_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  mwo_pkg::cordic_req_type  req,
   output mwo_pkg::cordic_rsp_type  rsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } state_type;

   localparam int XyW = mwo_pkg::CordicXyBits;
   localparam int ZW  = mwo_pkg::CordicZBits;
   localparam int SW  = mwo_pkg::SampleBits;

   state_type             state_ff;
   logic [4:0]            iter_ff;
   logic [1:0]            quad_ff;
   logic signed [XyW-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic signed [XyW-1:0] x_sh, y_sh, x_rnd, y_rnd;
   logic signed [SW-1:0]  cc, ss;
   logic                  done_ff;
   logic signed [SW-1:0]  cos_ff, sin_ff;

   // one micro-rotation per cycle
   always_comb begin
      x_sh = x_ff >>> iter_ff;
      y_sh = y_ff >>> iter_ff;
      if (!z_ff[ZW-1]) begin
         x_in = x_ff - y_sh;
         y_in = y_ff + x_sh;
         z_in = z_ff - ZW'(mwo_pkg::atan_entry(iter_ff));
      end else begin
         x_in = x_ff + y_sh;
         y_in = y_ff - x_sh;
         z_in = z_ff + ZW'(mwo_pkg::atan_entry(iter_ff));
      end
   end

   // round to sample format and clamp
   always_comb begin
      x_rnd = (x_ff + (XyW'(1) <<< (mwo_pkg::CordicShift - 1))) >>> mwo_pkg::CordicShift;
      y_rnd = (y_ff + (XyW'(1) <<< (mwo_pkg::CordicShift - 1))) >>> mwo_pkg::CordicShift;
      if (x_rnd > XyW'(mwo_pkg::OneF))           cc = mwo_pkg::OneF;
      else if (x_rnd < XyW'(mwo_pkg::MinusOneF)) cc = mwo_pkg::MinusOneF;
      else                                       cc = x_rnd[SW-1:0];
      if (y_rnd > XyW'(mwo_pkg::OneF))           ss = mwo_pkg::OneF;
      else if (y_rnd < XyW'(mwo_pkg::MinusOneF)) ss = mwo_pkg::MinusOneF;
      else                                       ss = y_rnd[SW-1:0];
   end

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req.start) begin
                  quad_ff  <= req.angle[mwo_pkg::PhaseBits-1 -: 2];
                  z_ff     <= ZW'({2'b00, req.angle[mwo_pkg::PhaseBits-3:0]});
                  x_ff     <= mwo_pkg::CordicGain;
                  y_ff     <= '0;
                  iter_ff  <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               x_ff    <= x_in;
               y_ff    <= y_in;
               z_ff    <= z_in;
               iter_ff <= iter_ff + 5'd1;
               if (iter_ff == 5'(mwo_pkg::CordicIters - 1)) state_ff <= ST_FIN;
            end
            ST_FIN: begin
               unique case (quad_ff)
                  2'd0: begin cos_ff <= cc;  sin_ff <= ss;  end
                  2'd1: begin cos_ff <= -ss; sin_ff <= cc;  end
                  2'd2: begin cos_ff <= -cc; sin_ff <= -ss; end
                  default: begin cos_ff <= ss; sin_ff <= -cc; end
               endcase
               done_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.cos_val = cos_ff;
   assign rsp.sin_val = sin_ff;

endmodule

[src/multi_waveform_oscillator.sv]
`timescale 1ns / 1ps

// Numerically controlled oscillator giving sine, sawtooth, square or triangle
// samples scaled by a per-request gain. One request is taken at a time: a
// request passes the rotation (sine) or waveform state, then the gain and
// output states, before the block can accept again. A frequency switch in
// sine mode adds an iterative cordic pass that recomputes the step sine and
// cosine. A response still waiting on the output holds the block in its
// output state until it is taken. A single shared 18x18 multiplier does the
// sine rotation (four products) and the gain scaling. After reset, and after
// a write of the increment, the phase or the sine mode, the block runs one
// or two cordic passes before it takes the next request.
module multi_waveform_oscillator (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_target_increment,
   input  logic        req_may_switch,
   input  logic [15:0] req_envelope_gain,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [17:0] rsp_sample,
   output logic        rsp_envelope_restart
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_DISPATCH,
      ST_ROT0,
      ST_ROT1,
      ST_ROT2,
      ST_ROT3,
      ST_ROT4,
      ST_WAVE,
      ST_GAIN,
      ST_OUT
   } state_type;

   localparam int PW = mwo_pkg::PhaseBits;
   localparam int SW = mwo_pkg::SampleBits;
   localparam int FB = mwo_pkg::FracBits;

   state_type              state_ff;
   mwo_pkg::wave_mode_type mode_ff;
   logic [PW-1:0]          phase_ff, inc_ff, new_inc;
   logic signed [SW-1:0]   cos_t_ff, sin_t_ff, cos_s_ff, sin_s_ff;
   logic signed [SW-1:0]   wave_ff, cnew_ff;
   logic [15:0]            gain_ff;
   logic                   restart_ff, item_ff, dest_step_ff;
   logic                   pend_step_ff, pend_theta_ff;
   logic                   rsp_valid_ff, rsp_restart_ff;
   logic signed [SW-1:0]   rsp_sample_ff;
   logic                   accept, do_switch;

   // shared multiplier
   logic signed [SW-1:0]   mul_a, mul_b;
   logic signed [2*SW-1:0] prod_ff;
   logic signed [2*SW:0]   acc_ff, sum_c, sum_s;
   logic signed [2*SW:0]   rnd_c, rnd_s;
   logic signed [SW-1:0]   clamp_c, clamp_s;
   logic signed [2*SW-1:0] rnd_g;
   logic signed [SW:0]     saw, saw_abs;
   logic signed [SW-1:0]   wave_calc;

   mwo_pkg::cordic_req_type cor_req;
   mwo_pkg::cordic_rsp_type cor_rsp;

   mwo_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cor_req),
      .rsp   (cor_rsp)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = !(state_ff == ST_IDLE && !pend_step_ff && !pend_theta_ff);
   assign do_switch = req_may_switch && (req_target_increment != inc_ff);
   assign new_inc   = do_switch ? req_target_increment : inc_ff;

   // cordic launch from the idle state
   always_comb begin
      cor_req.start = 1'b0;
      cor_req.angle = inc_ff;
      if (state_ff == ST_IDLE) begin
         if (pend_step_ff) begin
            cor_req.start = 1'b1;
         end else if (pend_theta_ff) begin
            cor_req.start = 1'b1;
            cor_req.angle = phase_ff;
         end else if (accept && do_switch && mode_ff == mwo_pkg::MODE_SINE) begin
            cor_req.start = 1'b1;
            cor_req.angle = req_target_increment;
         end
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_ROT0: begin mul_a = cos_t_ff; mul_b = cos_s_ff; end
         ST_ROT1: begin mul_a = sin_t_ff; mul_b = sin_s_ff; end
         ST_ROT2: begin mul_a = cos_t_ff; mul_b = sin_s_ff; end
         ST_ROT3: begin mul_a = sin_t_ff; mul_b = cos_s_ff; end
         default: begin mul_a = wave_ff;  mul_b = SW'({2'b00, gain_ff}); end
      endcase
   end

   // rotation rounding and clamping
   always_comb begin
      sum_c = acc_ff - (2*SW+1)'(prod_ff);
      sum_s = acc_ff + (2*SW+1)'(prod_ff);
      rnd_c = (sum_c + ((2*SW+1)'(1) <<< (FB - 1))) >>> FB;
      rnd_s = (sum_s + ((2*SW+1)'(1) <<< (FB - 1))) >>> FB;
      if (rnd_c > (2*SW+1)'(mwo_pkg::OneF))           clamp_c = mwo_pkg::OneF;
      else if (rnd_c < (2*SW+1)'(mwo_pkg::MinusOneF)) clamp_c = mwo_pkg::MinusOneF;
      else                                            clamp_c = rnd_c[SW-1:0];
      if (rnd_s > (2*SW+1)'(mwo_pkg::OneF))           clamp_s = mwo_pkg::OneF;
      else if (rnd_s < (2*SW+1)'(mwo_pkg::MinusOneF)) clamp_s = mwo_pkg::MinusOneF;
      else                                            clamp_s = rnd_s[SW-1:0];
      rnd_g = (prod_ff + ((2*SW)'(1) <<< (FB - 1))) >>> FB;
   end

   // waveforms derived from the phase
   always_comb begin
      saw     = (SW+1)'({1'b0, phase_ff[PW-1 -: FB+1]}) - (SW+1)'(mwo_pkg::OneF);
      saw_abs = saw[SW] ? -saw : saw;
      unique case (mode_ff)
         mwo_pkg::MODE_SAW: wave_calc = saw[SW-1:0];
         mwo_pkg::MODE_SQUARE:
            wave_calc = (phase_ff > (PW'(1) << (PW - 1))) ? mwo_pkg::OneF : mwo_pkg::MinusOneF;
         default: wave_calc = SW'((saw_abs <<< 1) - (SW+1)'(mwo_pkg::OneF));
      endcase
   end

   // sequencer, state and registered outputs
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= mwo_pkg::MODE_SINE;
         phase_ff      <= '0;
         inc_ff        <= '0;
         pend_step_ff  <= 1'b1;
         pend_theta_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         item_ff       <= 1'b0;
         dest_step_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (pend_step_ff) begin
                  pend_step_ff <= 1'b0;
                  dest_step_ff <= 1'b1;
                  item_ff      <= 1'b0;
                  state_ff     <= ST_CORDIC;
               end else if (pend_theta_ff) begin
                  pend_theta_ff <= 1'b0;
                  dest_step_ff  <= 1'b0;
                  item_ff       <= 1'b0;
                  state_ff      <= ST_CORDIC;
               end else if (accept) begin
                  inc_ff     <= new_inc;
                  phase_ff   <= phase_ff + new_inc;
                  gain_ff    <= req_envelope_gain;
                  restart_ff <= do_switch;
                  if (do_switch && mode_ff == mwo_pkg::MODE_SINE) begin
                     dest_step_ff <= 1'b1;
                     item_ff      <= 1'b1;
                     state_ff     <= ST_CORDIC;
                  end else begin
                     state_ff <= ST_DISPATCH;
                  end
               end
            end
            ST_CORDIC: begin
               if (cor_rsp.done) begin
                  if (dest_step_ff) begin
                     cos_s_ff <= cor_rsp.cos_val;
                     sin_s_ff <= cor_rsp.sin_val;
                  end else begin
                     cos_t_ff <= cor_rsp.cos_val;
                     sin_t_ff <= cor_rsp.sin_val;
                  end
                  state_ff <= item_ff ? ST_ROT0 : ST_IDLE;
               end
            end
            ST_DISPATCH:
               state_ff <= (mode_ff == mwo_pkg::MODE_SINE) ? ST_ROT0 : ST_WAVE;
            ST_ROT0: state_ff <= ST_ROT1;
            ST_ROT1: begin
               acc_ff   <= (2*SW+1)'(prod_ff);
               state_ff <= ST_ROT2;
            end
            ST_ROT2: begin
               cnew_ff  <= clamp_c;
               state_ff <= ST_ROT3;
            end
            ST_ROT3: begin
               acc_ff   <= (2*SW+1)'(prod_ff);
               state_ff <= ST_ROT4;
            end
            ST_ROT4: begin
               sin_t_ff <= clamp_s;
               cos_t_ff <= cnew_ff;
               wave_ff  <= cnew_ff;
               state_ff <= ST_GAIN;
            end
            ST_WAVE: begin
               wave_ff  <= wave_calc;
               state_ff <= ST_GAIN;
            end
            ST_GAIN: state_ff <= ST_OUT;
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_sample_ff  <= rnd_g[SW-1:0];
                  rsp_restart_ff <= restart_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // register writes, after the sequencer so a new write wins
         if (csr_wr_en) begin
            unique case (mwo_pkg::reg_index_type'(csr_index))
               mwo_pkg::REG_WAVE_MODE: begin
                  mode_ff <= mwo_pkg::wave_mode_type'(csr_wdata[1:0]);
                  if (csr_wdata[1:0] == mwo_pkg::MODE_SINE) begin
                     pend_step_ff  <= 1'b1;
                     pend_theta_ff <= 1'b1;
                  end
               end
               mwo_pkg::REG_INIT_INC: begin
                  inc_ff       <= csr_wdata;
                  pend_step_ff <= 1'b1;
               end
               mwo_pkg::REG_INIT_PH: begin
                  phase_ff      <= csr_wdata;
                  pend_theta_ff <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sample           = rsp_sample_ff;
   assign rsp_envelope_restart = rsp_restart_ff;

endmodule

[src/mwo_checker.sv]
`timescale 1ns / 1ps

module mwo_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [17:0] rsp_sample,
   input logic               rsp_envelope_restart
);

   // a held result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample)
         && $stable(rsp_envelope_restart))
      else $error("stalled result changed");

   // sample stays within one full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample <= 18'sd65536) && (rsp_sample >= -18'sd65536))
      else $error("sample out of range");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // start-up cordic passes hold off requests
   assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken right after reset");

endmodule

bind multi_waveform_oscillator mwo_checker u_mwo_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_sample           (rsp_sample),
   .rsp_envelope_restart (rsp_envelope_restart)
);

[test/multi_waveform_oscillator_check.sv]
`timescale 1ns / 1ps

module multi_waveform_oscillator_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [31:0]        req_target_increment,
   input  logic               req_may_switch,
   input  logic [15:0]        req_envelope_gain,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [17:0] rsp_sample,
   input  logic               rsp_envelope_restart,
   output int                 error_count,
   output int                 outstanding
);

   typedef struct {
      logic [17:0] sample;
      logic        restart;
   } tone_type;

   tone_type pending_tones[$];

   mwo_pkg::wave_mode_type mode;
   logic [31:0]    phase;
   logic [31:0]    step_inc;
   longint         sin_ph, cos_ph, sin_inc, cos_inc;

   localparam longint Unit = 64'sd65536;

   function automatic longint clamp_unit(input longint v);
      if (v > Unit) return Unit;
      if (v < -Unit) return -Unit;
      return v;
   endfunction

   function automatic longint round_shift(input longint v, input int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   // iterative rotation of a turn fraction into cosine and sine
   task automatic sin_cos(input logic [31:0] angle, output longint c, output longint s);
      longint x, y, z, nx, ny, cc, ss;
      longint atan_val;
      x = 64'sd652032874;
      y = 0;
      z = longint'(angle[29:0]);
      for (int i = 0; i < 30; i++) begin
         atan_val = longint'(mwo_pkg::atan_entry(5'(i)));
         if (z >= 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z  = z - atan_val;
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z  = z + atan_val;
         end
         x = nx;
         y = ny;
      end
      cc = clamp_unit(round_shift(x, 14));
      ss = clamp_unit(round_shift(y, 14));
      case (angle[31:30])
         2'd0: begin c = cc;  s = ss;  end
         2'd1: begin c = -ss; s = cc;  end
         2'd2: begin c = -cc; s = -ss; end
         default: begin c = ss; s = -cc; end
      endcase
   endtask

   // next sample for one request
   task automatic next_tone(input logic [31:0] target, input logic may,
                            input logic [15:0] gain, output tone_type t);
      longint wave, saw, c, s;
      t.restart = 1'b0;
      if (may && target != step_inc) begin
         step_inc  = target;
         t.restart = 1'b1;
         if (mode == mwo_pkg::MODE_SINE) sin_cos(step_inc, cos_inc, sin_inc);
      end
      phase = phase + step_inc;
      if (mode == mwo_pkg::MODE_SINE) begin
         c = clamp_unit(round_shift(cos_ph * cos_inc - sin_ph * sin_inc, 16));
         s = clamp_unit(round_shift(cos_ph * sin_inc + sin_ph * cos_inc, 16));
         cos_ph = c;
         sin_ph = s;
         wave = c;
      end else begin
         saw = longint'(phase[31:15]) - Unit;
         if (mode == mwo_pkg::MODE_SAW) wave = saw;
         else if (mode == mwo_pkg::MODE_SQUARE) wave = (phase > 32'h80000000) ? Unit : -Unit;
         else wave = 2 * (saw < 0 ? -saw : saw) - Unit;
      end
      t.sample = 18'(round_shift(longint'(gain) * wave, 16));
   endtask

   assign outstanding = pending_tones.size();

   // track settings, predict on request, compare on response
   always @(posedge clock) begin
      tone_type t, want;
      int errs;
      errs = 0;
      if (reset) begin
         mode     = mwo_pkg::MODE_SINE;
         phase    = '0;
         step_inc = '0;
         sin_cos(phase, cos_ph, sin_ph);
         sin_cos(step_inc, cos_inc, sin_inc);
         pending_tones.delete();
         error_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (mwo_pkg::reg_index_type'(csr_index))
               mwo_pkg::REG_WAVE_MODE: begin
                  mode = mwo_pkg::wave_mode_type'(csr_wdata[1:0]);
                  if (mode == mwo_pkg::MODE_SINE) begin
                     sin_cos(step_inc, cos_inc, sin_inc);
                     sin_cos(phase, cos_ph, sin_ph);
                  end
               end
               mwo_pkg::REG_INIT_INC: begin
                  step_inc = csr_wdata;
                  sin_cos(step_inc, cos_inc, sin_inc);
               end
               mwo_pkg::REG_INIT_PH: begin
                  phase = csr_wdata;
                  sin_cos(phase, cos_ph, sin_ph);
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            next_tone(req_target_increment, req_may_switch, req_envelope_gain, t);
            pending_tones.push_back(t);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_tones.size() == 0) begin
               $display("%0t: unexpected response sample %0d restart %0b", $time,
                        rsp_sample, rsp_envelope_restart);
               errs++;
            end else begin
               want = pending_tones.pop_front();
               if (want.sample !== rsp_sample) begin
                  $display("%0t: sample expected %0d actual %0d", $time,
                           $signed(want.sample), rsp_sample);
                  errs++;
               end
               if (want.restart !== rsp_envelope_restart) begin
                  $display("%0t: envelope restart expected %0b actual %0b", $time,
                           want.restart, rsp_envelope_restart);
                  errs++;
               end
            end
         end
         error_count <= error_count + errs;
      end
   end

endmodule

[test/multi_waveform_oscillator_test.sv]
`timescale 1ns / 1ps

module multi_waveform_oscillator_test;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = mwo_pkg::REG_WAVE_MODE;
   logic [31:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [31:0]        req_target_increment = '0;
   logic               req_may_switch = 1'b0;
   logic [15:0]        req_envelope_gain = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [17:0] rsp_sample;
   logic               rsp_envelope_restart;
   int                 error_count;
   int                 outstanding;
   logic               no_idle = 1'b0;
   logic [31:0]        last_target = '0;

   multi_waveform_oscillator DUT (.*);

   multi_waveform_oscillator_check checker_inst (.*);

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response back-pressure
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 27);
   end

   // run limit
   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   task automatic write_reg(input mwo_pkg::reg_index_type idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // present one request and hold it until taken
   task automatic send_request(input logic [31:0] target, input logic may,
                               input logic [15:0] gain);
      logic taken;
      while (!no_idle && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_target_increment <= target;
      req_may_switch       <= may;
      req_envelope_gain    <= gain;
      last_target = target;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_target();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return last_target;
      if (r < 36) return 32'h0;
      if (r < 42) return 32'h80000000;
      if (r < 55) return $urandom_range(0, 32'h00400000);
      return $urandom_range(0, 32'h80000000);
   endfunction

   function automatic logic [15:0] pick_gain();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   initial begin
      logic [31:0] g;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of every field in every mode
      for (int m = 0; m < 4; m++) begin
         write_reg(mwo_pkg::REG_WAVE_MODE, 32'(m));
         send_request(32'h80000000, 1'b1, 16'hFFFF);
         send_request(32'h80000000, 1'b1, 16'hFFFF);
         send_request(32'h00000000, 1'b0, 16'hFFFF);
         send_request(32'h00000000, 1'b1, 16'h0000);
         send_request(32'h7FFFFFFF, 1'b1, 16'h8001);
         drain();
      end
      write_reg(mwo_pkg::REG_NONE, 32'hFFFFFFFF);
      write_reg(mwo_pkg::REG_INIT_PH, 32'hFFFFFFFF);
      write_reg(mwo_pkg::REG_INIT_INC, 32'h80000000);
      send_request(32'h80000000, 1'b0, 16'hFFFF);
      send_request(32'h55555555, 1'b1, 16'h7FFF);
      drain();

      // random phases under varied settings
      for (int p = 0; p < 12; p++) begin
         no_idle = (p == 5);
         write_reg(mwo_pkg::REG_WAVE_MODE, 32'($urandom_range(0, 3)));
         case (p % 4)
            0: write_reg(mwo_pkg::REG_INIT_INC, 32'h0);
            1: write_reg(mwo_pkg::REG_INIT_INC, 32'h80000000);
            default: write_reg(mwo_pkg::REG_INIT_INC, $urandom_range(0, 32'h80000000));
         endcase
         case (p % 3)
            0: write_reg(mwo_pkg::REG_INIT_PH, 32'h0);
            1: write_reg(mwo_pkg::REG_INIT_PH, 32'hFFFFFFFF);
            default: write_reg(mwo_pkg::REG_INIT_PH, $urandom);
         endcase
         // occasionally a second random mode write; a non-sine one leaves the sine state alone
         if (p % 4 == 2) write_reg(mwo_pkg::REG_WAVE_MODE, 32'($urandom_range(0, 3)));
         repeat (100) begin
            g = pick_target();
            send_request(g, $urandom_range(0, 99) < 35, pick_gain());
         end
         drain();
      end
      no_idle = 1'b0;

      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[multi_waveform_oscillator.f]
src/mwo_pkg.sv
src/mwo_cordic.sv
src/multi_waveform_oscillator.sv
src/mwo_checker.sv
test/multi_waveform_oscillator_check.sv
test/multi_waveform_oscillator_test.sv
